@@ sv/imufp_pkg.sv @@
// Shared types and codes for the IMU frame parser with yaw unwrapping.
// No dependencies; imported by the top level, the yaw tracker and the checker.
package imufp_pkg;

    // Frame kind codes as reported on the result channel
    localparam logic [1:0] KIND_ACCEL = 2'd0;
    localparam logic [1:0] KIND_GYRO  = 2'd1;
    localparam logic [1:0] KIND_ANGLE = 2'd2;
    localparam logic [1:0] KIND_OTHER = 2'd3;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_ID   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_ID    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_ID   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_THR   = 3'd4;
    localparam int unsigned CFG_DATA_W = 16;

    // Register reset values
    localparam logic [7:0]  START_BYTE_RST = 8'd85;
    localparam logic [7:0]  ACCEL_ID_RST   = 8'd81;
    localparam logic [7:0]  GYRO_ID_RST    = 8'd82;
    localparam logic [7:0]  ANGLE_ID_RST   = 8'd83;
    localparam logic [15:0] WRAP_THR_RST   = 16'd54613;

    // Decoded frame handed from the parser stage to the yaw tracker
    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
    } dec_t;

endpackage

@@ sv/imufp_byte_cell.sv @@
// One cell of the frame byte chain: holds one byte, passes it on when shifting.
// Depends on nothing; instantiated in a row by the top level.
module imufp_byte_cell (
    input  logic       aclk,
    input  logic       shift_en,
    input  logic [7:0] d_in,
    output logic [7:0] q_out
);

    logic [7:0] byte_reg;

    // Payload only, no reset needed
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            byte_reg <= d_in;
        end
    end

    assign q_out = byte_reg;

endmodule

@@ sv/imufp_yaw_track.sv @@
// Yaw turn tracker: holds last raw yaw and a saturating turn count.
// Depends on imufp_pkg (dec_t, KIND_ANGLE).
module imufp_yaw_track #(
    parameter int unsigned TURN_BITS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        upd_en,
    input  imufp_pkg::dec_t             dec,
    input  logic [15:0]                 wrap_thr,
    output logic signed [TURN_BITS-1:0] turns,
    output logic signed [15:0]          last_yaw
);
    import imufp_pkg::*;

    localparam logic signed [TURN_BITS-1:0] TURN_HI = {1'b0, {(TURN_BITS-1){1'b1}}};
    localparam logic signed [TURN_BITS-1:0] TURN_LO = ~TURN_HI + 1'b1;

    logic signed [TURN_BITS-1:0] turns_reg, turns_next;
    logic signed [15:0]          yaw_reg, yaw_next;
    logic signed [16:0]          diff;
    logic signed [16:0]          thr_pos;
    logic signed [16:0]          thr_neg;

    // Jump detection against the previous raw yaw; small jumps leave turns alone
    always_comb begin
        diff       = 17'(dec.az) - 17'(yaw_reg);
        thr_pos    = signed'({1'b0, wrap_thr});
        thr_neg    = -thr_pos;
        turns_next = turns_reg;
        yaw_next   = yaw_reg;
        if (dec.kind == KIND_ANGLE) begin
            yaw_next = dec.az;
            if (diff > thr_pos) begin
                if (turns_reg > TURN_LO) turns_next = turns_reg - 1'b1;
            end else if (diff < thr_neg) begin
                if (turns_reg < TURN_HI) turns_next = turns_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            turns_reg <= '0;
            yaw_reg   <= '0;
        end else if (upd_en) begin
            turns_reg <= turns_next;
            yaw_reg   <= yaw_next;
        end
    end

    assign turns    = turns_reg;
    assign last_yaw = yaw_reg;

endmodule

@@ sv/imu_frame_parser_yaw_unwrap.sv @@
// IMU serial frame parser with sum checksum and yaw turn unwrapping.
// A frame's result passes the decode stage register, then the output register.
// Throughput: one byte per cycle while s_ready is high; cells shift on frame bytes.
// Reset (aresetn low, synchronous): parser waits for start, registers back to
// defaults, turns and last yaw cleared, no result pending. Depends on imufp_pkg.
module imu_frame_parser_yaw_unwrap #(
    parameter int unsigned FRAME_BYTES = 11,
    parameter int unsigned TURN_BITS   = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [imufp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [imufp_pkg::CFG_DATA_W-1:0]     cfg_data,
    // byte input channel
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [7:0]                           s_rx_byte,
    // result channel
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [1:0]                           m_frame_kind,
    output logic signed [15:0]                   m_axis_x,
    output logic signed [15:0]                   m_axis_y,
    output logic signed [15:0]                   m_axis_z,
    output logic signed [15:0]                   m_turn_count,
    output logic signed [31:0]                   m_unwrapped_yaw
);
    import imufp_pkg::*;

    localparam int unsigned CELLS = FRAME_BYTES - 1;
    localparam int unsigned CNT_W = $clog2(FRAME_BYTES);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(FRAME_BYTES - 1);

    // Configuration registers
    logic [7:0]  start_byte_reg, accel_id_reg, gyro_id_reg, angle_id_reg;
    logic [15:0] wrap_thr_reg;

    // Parser control
    logic             in_frame_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [7:0]       sum_reg;
    logic             s_fire, shift_en, last_byte, p_load, o_load;

    // Byte chain
    logic [7:0] cell_q [CELLS];
    logic [7:0] view [8];

    // Decode stage and output stage
    dec_t dec_now, p_reg, o_reg;
    logic p_valid_reg, o_valid_reg;
    logic signed [TURN_BITS-1:0] turns;
    logic signed [15:0]          last_yaw;

    // Configuration port, always ready
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_byte_reg <= START_BYTE_RST;
            accel_id_reg   <= ACCEL_ID_RST;
            gyro_id_reg    <= GYRO_ID_RST;
            angle_id_reg   <= ANGLE_ID_RST;
            wrap_thr_reg   <= WRAP_THR_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_START_BYTE: start_byte_reg <= cfg_data[7:0];
                CFG_ACCEL_ID:   accel_id_reg   <= cfg_data[7:0];
                CFG_GYRO_ID:    gyro_id_reg    <= cfg_data[7:0];
                CFG_ANGLE_ID:   angle_id_reg   <= cfg_data[7:0];
                CFG_WRAP_THR:   wrap_thr_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Handshake and pipeline enables
    assign o_load    = p_valid_reg && (!o_valid_reg || m_ready);
    assign s_ready   = !p_valid_reg || o_load;
    assign s_fire    = s_valid && s_ready;
    assign last_byte = in_frame_reg && (cnt_reg == LAST_CNT);
    assign shift_en  = s_fire && (in_frame_reg || (s_rx_byte == start_byte_reg));
    assign p_load    = s_fire && last_byte && (sum_reg == s_rx_byte);

    // Frame framing, byte count and running checksum
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            cnt_reg      <= '0;
        end else if (s_fire) begin
            if (!in_frame_reg) begin
                if (s_rx_byte == start_byte_reg) begin
                    in_frame_reg <= 1'b1;
                    cnt_reg      <= CNT_W'(1);
                end
            end else if (last_byte) begin
                in_frame_reg <= 1'b0;
                cnt_reg      <= '0;
            end else begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            if (!in_frame_reg) begin
                sum_reg <= s_rx_byte;
            end else begin
                sum_reg <= sum_reg + s_rx_byte;
            end
        end
    end

    // Row of byte cells; byte j of the frame sits in cell CELLS-1-j
    genvar k;
    generate
        for (k = 0; k < CELLS; k++) begin : g_cell
            if (k == 0) begin : g_head
                imufp_byte_cell u_cell (
                    .aclk     (aclk),
                    .shift_en (shift_en),
                    .d_in     (s_rx_byte),
                    .q_out    (cell_q[k])
                );
            end else begin : g_body
                imufp_byte_cell u_cell (
                    .aclk     (aclk),
                    .shift_en (shift_en),
                    .d_in     (cell_q[k-1]),
                    .q_out    (cell_q[k])
                );
            end
        end

        // Frame bytes 0..7 as seen while the last byte is on the input
        for (k = 0; k < 8; k++) begin : g_view
            if (k < CELLS) begin : g_cell_byte
                assign view[k] = cell_q[CELLS-1-k];
            end else if (k == CELLS) begin : g_last_byte
                assign view[k] = s_rx_byte;
            end else begin : g_absent
                assign view[k] = 8'd0;
            end
        end
    endgenerate

    // Classify by ID byte and pick up the three axes
    always_comb begin
        priority if (view[1] == accel_id_reg) dec_now.kind = KIND_ACCEL;
        else if (view[1] == gyro_id_reg)      dec_now.kind = KIND_GYRO;
        else if (view[1] == angle_id_reg)     dec_now.kind = KIND_ANGLE;
        else                                  dec_now.kind = KIND_OTHER;
        dec_now.ax = signed'({view[3], view[2]});
        dec_now.ay = signed'({view[5], view[4]});
        dec_now.az = signed'({view[7], view[6]});
    end

    // Decode stage register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (p_load) begin
            p_valid_reg <= 1'b1;
        end else if (o_load) begin
            p_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (p_load) begin
            p_reg <= dec_now;
        end
    end

    // Yaw state advances as the item enters the output register
    imufp_yaw_track #(
        .TURN_BITS (TURN_BITS)
    ) u_yaw (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .upd_en   (o_load),
        .dec      (p_reg),
        .wrap_thr (wrap_thr_reg),
        .turns    (turns),
        .last_yaw (last_yaw)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
        end else if (o_load) begin
            o_valid_reg <= 1'b1;
        end else if (m_ready) begin
            o_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (o_load) begin
            o_reg <= p_reg;
        end
    end

    assign m_valid      = o_valid_reg;
    assign m_frame_kind = o_reg.kind;
    assign m_axis_x     = o_reg.ax;
    assign m_axis_y     = o_reg.ay;
    assign m_axis_z     = o_reg.az;
    assign m_turn_count = 16'(turns);
    // turns * 65536 + sign-extended yaw: upper half takes a borrow for negative yaw
    assign m_unwrapped_yaw = {m_turn_count + {16{last_yaw[15]}}, last_yaw};

endmodule

@@ sv/imufp_checker.sv @@
// Port-level checks for imu_frame_parser_yaw_unwrap, bound to the top level.
// Depends on imufp_pkg (KIND_ANGLE) and the top level's port names.
module imufp_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic [1:0]         m_frame_kind,
    input logic signed [15:0] m_axis_z,
    input logic signed [15:0] m_turn_count,
    input logic signed [31:0] m_unwrapped_yaw
);
    import imufp_pkg::*;

    // No result right after reset
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A stalled item stays valid and keeps its unwrapped yaw
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_unwrapped_yaw))
        else $error("stalled item changed");

    // Turn count saturates short of the most negative code
    a_turn_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_turn_count != 16'sh8000)
        else $error("turn count out of range");

    // Angle items carry their own raw yaw in the low half of the unwrapped value
    a_angle_yaw: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_frame_kind == KIND_ANGLE) |-> m_unwrapped_yaw[15:0] == m_axis_z)
        else $error("unwrapped yaw does not match angle axis");

endmodule

bind imu_frame_parser_yaw_unwrap imufp_checker u_imufp_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_frame_kind    (m_frame_kind),
    .m_axis_z        (m_axis_z),
    .m_turn_count    (m_turn_count),
    .m_unwrapped_yaw (m_unwrapped_yaw)
);
